@@ rtl/ccacc_pkg.sv @@
// shared constants and codes for the cross-correlator accumulator
package ccacc_pkg;

  localparam int MAX_STATIONS_DEF = 64;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int ACC_BITS_DEF     = 64;

  localparam int STATION_W  = 6;
  localparam int SAMPLE_IN_W = 16;
  localparam int VIS_W      = 64;
  localparam int NUM_ST_W   = 7;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 128;

  localparam logic [NUM_ST_W-1:0] NUM_STATIONS_RST = 7'd64;

  // register index taken from paddr[2]
  localparam logic REG_NUM_STATIONS = 1'b0;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

@@ rtl/ccacc_cmac.sv @@
// shared complex multiply-accumulate unit with saturating add
module ccacc_cmac import ccacc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = ACC_BITS_DEF
) (
  input  logic                       clk,
  input  logic signed [SAMPLE_BITS-1:0] ar,
  input  logic signed [SAMPLE_BITS-1:0] ai,
  input  logic signed [SAMPLE_BITS-1:0] br,
  input  logic signed [SAMPLE_BITS-1:0] bi,
  input  logic signed [ACC_BITS-1:0]    acc_re,
  input  logic signed [ACC_BITS-1:0]    acc_im,
  output logic signed [ACC_BITS-1:0]    sum_re,
  output logic signed [ACC_BITS-1:0]    sum_im
);

  localparam int PW = 2*SAMPLE_BITS;
  localparam int DW = PW + 1;

  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic signed [DW-1:0] d_re_r, d_im_r;

  // stage 1: four partial products, stage 2: real and imaginary sums
  always_ff @(posedge clk) begin
    p_rr_r <= ar * br;
    p_ii_r <= ai * bi;
    p_ir_r <= ai * br;
    p_ri_r <= ar * bi;
    d_re_r <= DW'(p_rr_r) + DW'(p_ii_r);
    d_im_r <= DW'(p_ir_r) - DW'(p_ri_r);
  end

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a,
    input logic signed [DW-1:0]       d
  );
    logic signed [ACC_BITS:0] s;
    logic signed [ACC_BITS-1:0] r;
    s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(d);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      r = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      r = s[ACC_BITS-1:0];
    end
    return r;
  endfunction

  assign sum_re = sat_add(acc_re, d_re_r);
  assign sum_im = sat_add(acc_im, d_im_r);

endmodule

@@ rtl/cross_correlator_accumulator_core.sv @@
// top level: sequencer, sample store and accumulator memory of the correlator
//
// channel | direction | handshake          | payload
// in_     | in        | in_tvalid/tready   | tuser op, tdata stations, pair, sample
// out_    | out       | out_tvalid/tready  | tuser status, tdata visibility
// cfg_    | in        | apb psel/penable   | num_stations at address 0
//
// a sample runs, for each baseline up to its station, one sample memory read and then
// one pass of the shared cmac unit per product: accumulator read, sum and write.
// a read passes S_RRD and S_RDAT; a clear writes zero to all ACC_DEPTH entries.
// after reset a clearing pass over all ACC_DEPTH entries runs before the first transfer.
// a result waiting on out_tready holds the block before it loads the next one.
module cross_correlator_accumulator_core import ccacc_pkg::*; #(
  parameter int MAX_STATIONS = MAX_STATIONS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int ACC_BITS     = ACC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // station[5:0], other_station[11:6], polarization_pair[13:12], x_real[29:14],
  // x_imag[45:30], y_real[61:46], y_imag[77:62], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // vis_real[63:0], vis_imag[127:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  output logic                  out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SIDX_W    = $clog2(MAX_STATIONS);
  localparam int ACC_DEPTH = MAX_STATIONS * (MAX_STATIONS + 1) / 2 * 4;
  localparam int AW        = $clog2(ACC_DEPTH);
  localparam int BW        = AW - 2;
  localparam int SB        = SAMPLE_BITS;
  localparam int SMP_W     = 4 * SAMPLE_BITS;
  localparam int MEM_W     = 2 * ACC_BITS;
  localparam logic [AW-1:0] CLR_LAST = AW'(ACC_DEPTH - 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SRD   = 8'b0000_0100,
    S_ARD   = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_WR    = 8'b0010_0000,
    S_RRD   = 8'b0100_0000,
    S_RDAT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [NUM_ST_W-1:0] num_st_r;
  logic                cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & (cfg_paddr[2] == REG_NUM_STATIONS);
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_STATIONS) ?
                      CFG_DW'(num_st_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_st_r <= NUM_STATIONS_RST;
    end else if (cfg_wr) begin
      num_st_r <= cfg_pwdata[NUM_ST_W-1:0];
    end
  end

  // input fields
  logic [1:0]             in_op;
  logic [STATION_W-1:0]   in_st, in_ot;
  logic [1:0]             in_pp;
  logic [SAMPLE_IN_W-1:0] in_xr, in_xi, in_yr, in_yi;
  logic                   in_acc;
  assign in_op = in_tuser;
  assign in_st = in_tdata[5:0];
  assign in_ot = in_tdata[11:6];
  assign in_pp = in_tdata[13:12];
  assign in_xr = in_tdata[29:14];
  assign in_xi = in_tdata[45:30];
  assign in_yr = in_tdata[61:46];
  assign in_yi = in_tdata[77:62];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid & in_tready;

  logic [8:0] lim;
  logic       st_bad;
  assign lim = ({2'b0, num_st_r} < 9'(MAX_STATIONS)) ? {2'b0, num_st_r} : 9'(MAX_STATIONS);
  assign st_bad = ({3'b0, in_st} >= lim);

  logic [12:0] st13, tri13;
  assign st13  = 13'(in_st);
  assign tri13 = (st13 * (st13 + 13'd1)) >> 1;

  // item registers
  logic [STATION_W-1:0] st_r, ot_r;
  logic [1:0]           pp_r;
  logic [BW-1:0]        tri_r;
  logic                 bad_r;
  logic [SMP_W-1:0]     smp_r;
  logic [SMP_W-1:0]     in_smp;
  assign in_smp = {in_yi[SB-1:0], in_yr[SB-1:0], in_xi[SB-1:0], in_xr[SB-1:0]};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_r  <= in_st;
      ot_r  <= in_ot;
      pp_r  <= in_pp;
      tri_r <= BW'(tri13);
      bad_r <= st_bad | (in_ot > in_st);
      smp_r <= in_smp;
    end
  end

  // sequencer counters
  logic [SIDX_W-1:0] o_r, o_nxt;
  logic [1:0]        p_r, p_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              last_o;
  assign last_o = (o_r == SIDX_W'(st_r));

  // sample store, undefined until written
  logic [SMP_W-1:0] smem [MAX_STATIONS];
  logic [SMP_W-1:0] smem_q_r;
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_SAMPLE && !st_bad) begin
      smem[SIDX_W'(in_st)] <= in_smp;
    end
    smem_q_r <= smem[o_r];
  end

  // accumulator memory, {im, re} per entry
  logic [MEM_W-1:0] amem [ACC_DEPTH];
  logic [MEM_W-1:0] acc_q_r;
  logic [AW-1:0]    mac_addr, rd_addr, acc_raddr, acc_waddr;
  logic [MEM_W-1:0] acc_wdata;
  logic             acc_we;
  logic signed [ACC_BITS-1:0] sum_re, sum_im;

  assign mac_addr  = {tri_r + BW'(o_r), p_r};
  assign rd_addr   = {tri_r + BW'(ot_r), pp_r};
  assign acc_raddr = (state_r == S_RRD || state_r == S_RDAT) ? rd_addr : mac_addr;
  assign acc_we    = (state_r == S_CLEAR) || (state_r == S_WR);
  assign acc_waddr = (state_r == S_CLEAR) ? clr_r : mac_addr;
  assign acc_wdata = (state_r == S_CLEAR) ? '0 : {sum_im, sum_re};

  always_ff @(posedge clk) begin
    if (acc_we) begin
      amem[acc_waddr] <= acc_wdata;
    end
    acc_q_r <= amem[acc_raddr];
  end

  // operand select: pair bit 1 picks a's polarization, bit 0 picks b's
  logic signed [SB-1:0] ar, ai, br, bi;
  assign ar = p_r[1] ? smp_r[2*SB +: SB]    : smp_r[0 +: SB];
  assign ai = p_r[1] ? smp_r[3*SB +: SB]    : smp_r[SB +: SB];
  assign br = p_r[0] ? smem_q_r[2*SB +: SB] : smem_q_r[0 +: SB];
  assign bi = p_r[0] ? smem_q_r[3*SB +: SB] : smem_q_r[SB +: SB];

  ccacc_cmac #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_cmac (
    .clk   (clk),
    .ar    (ar),
    .ai    (ai),
    .br    (br),
    .bi    (bi),
    .acc_re(acc_q_r[ACC_BITS-1:0]),
    .acc_im(acc_q_r[MEM_W-1:ACC_BITS]),
    .sum_re(sum_re),
    .sum_im(sum_im)
  );

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_stat_r;
  logic                  out_load;
  logic signed [ACC_BITS-1:0] vis_re, vis_im;
  assign out_load = (state_r == S_RDAT) && (!out_valid_r || out_tready);
  assign vis_re = acc_q_r[ACC_BITS-1:0];
  assign vis_im = acc_q_r[MEM_W-1:ACC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= bad_r ? '0 : {VIS_W'(vis_im), VIS_W'(vis_re)};
      out_stat_r <= bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    o_nxt     = o_r;
    p_nxt     = p_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_SAMPLE) begin
            if (!st_bad) begin
              state_nxt = S_SRD;
              o_nxt     = '0;
              p_nxt     = '0;
            end
          end else if (in_op == OP_READ) begin
            state_nxt = S_RRD;
          end else if (in_op == OP_CLEAR) begin
            state_nxt = S_CLEAR;
            clr_nxt   = '0;
          end
        end
      end
      S_SRD: state_nxt = S_ARD;
      S_ARD: state_nxt = S_SUM;
      S_SUM: state_nxt = S_WR;
      S_WR: begin
        p_nxt = p_r + 2'd1;
        if (p_r == 2'd3) begin
          if (last_o) begin
            state_nxt = S_IDLE;
          end else begin
            o_nxt     = o_r + SIDX_W'(1);
            state_nxt = S_SRD;
          end
        end else begin
          state_nxt = S_ARD;
        end
      end
      S_RRD: state_nxt = S_RDAT;
      S_RDAT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      o_r     <= '0;
      p_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      o_r     <= o_nxt;
      p_r     <= p_nxt;
    end
  end

`ifndef SYNTHESIS
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RDAT))
    else $error("result raised outside the read path");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_CLEAR) && (clr_r == '0))
    else $error("reset did not start the clearing pass");

  a_baseline_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> ({{(STATION_W+1){1'b0}}, o_r} <= (STATION_W+1+SIDX_W)'(st_r)))
    else $error("baseline beyond the sample's station");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ARD) |=> (state_r == S_SUM) && $stable(p_r) && $stable(o_r))
    else $error("mac pass disturbed");
`endif

endmodule
